/* hw/rtl/tslm_pkg.sv */
// ----------------------------------------------------------------------------
// tslm_pkg
// Shared constants, field widths and the tanh lookup table of the tape
// saturation block. The table is built at elaboration in Q2.30 steps.
// ----------------------------------------------------------------------------
package tslm_pkg;

  // Sizes of the shaper and of the per-channel filter memory
  localparam int TANH_DEPTH = 256;
  localparam int CHANNELS   = 2;

  // Field and register widths
  localparam int SAMPLE_W = 24;
  localparam int DRIVE_W  = 15;
  localparam int POLE_W   = 16;
  localparam int WET_W    = 17;
  localparam int CFG_W    = 17;
  localparam int CFG_IDX_W = 2;
  localparam int TAB_W    = 23;
  localparam int IDX_W    = $clog2(TANH_DEPTH + 1);
  localparam int SLOT_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Register reset values
  localparam logic [DRIVE_W-1:0] DRIVE_RST = DRIVE_W'(11469);
  localparam logic [POLE_W-1:0]  POLE_RST  = POLE_W'(60000);
  localparam logic [WET_W-1:0]   WET_RST   = WET_W'(65536);

  // Register indexes on the write port
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLE_COEFF   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WET_FRACTION = 2'd2;

  // Q0.16 constants
  localparam int Q16_ONE    = 65536;
  localparam int SCALE_085  = 55706;
  localparam int ROUND_HALF = 32768;

  // Q2.30 helpers for the table build
  localparam logic [63:0] Q30_ONE  = 64'd1 << 30;
  localparam logic [63:0] Q30_HALF = 64'd1 << 29;

  typedef logic [TAB_W-1:0] tab_t [TANH_DEPTH+1];

  function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
    return (a * b + Q30_HALF) >> 30;
  endfunction

  // Restoring shift-subtract quotient; the quotients here stay below 2^32
  function automatic logic [63:0] div_q32(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = n;
    quo = '0;
    for (int b = 31; b >= 0; b--) begin
      if (rem >= (d << b)) begin
        rem    = rem - (d << b);
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // tanh(4*i/depth): series at 1/64 scale, then six double-angle steps
  function automatic tab_t build_tanh_tab();
    tab_t        tab;
    logic [63:0] ii;
    logic [63:0] v;
    logic [63:0] v2;
    logic [63:0] v3;
    logic [63:0] v5;
    logic [63:0] t;
    logic [63:0] den;
    for (int i = 0; i <= TANH_DEPTH; i++) begin
      ii = 64'(i);
      v  = ((ii << 26) + 64'(TANH_DEPTH / 2)) / TANH_DEPTH;
      v2 = q30_mul(v, v);
      v3 = q30_mul(v2, v);
      v5 = q30_mul(v3, v2);
      t  = v - (v3 + 64'd1) / 3 + (64'd2 * v5 + 64'd7) / 15;
      for (int r = 0; r < 6; r++) begin
        den = Q30_ONE + q30_mul(t, t);
        t   = div_q32((t << 31) + (den >> 1), den);
      end
      t = (t + 64'd128) >> 8;
      if (t > 64'h7F_FFFF) begin
        t = 64'h7F_FFFF;
      end
      tab[i] = t[TAB_W-1:0];
    end
    return tab;
  endfunction

  localparam tab_t TANH_TAB = build_tanh_tab();

endpackage

/* hw/rtl/tape_saturation_lowpass_mix.sv */
// ----------------------------------------------------------------------------
// tape_saturation_lowpass_mix
// Drive gain, table tanh shaper, 0.85 scale, per-channel one-pole lowpass and
// dry/wet mix, run by a microprogram over one shared 25x18 multiplier.
// ----------------------------------------------------------------------------
// The program handles one sample at a time; eight steps use the shared
// multiplier, the rest wait, latch the index, read the table, emit. Emit holds
// while the output is stalled; a new sample is taken only in idle.
// A finished sample waits in the output register while the next one is taken.
// Reset (rst_ni low, asynchronous): sequencer idle, output empty, registers at
// their defaults, both lowpass memories cleared.
module tape_saturation_lowpass_mix (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port
  input  logic                           cfg_we_i,
  input  logic [tslm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tslm_pkg::CFG_W-1:0]     cfg_wdata_i,
  // Input stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [23:0]                    s_axis_tdata_i,  // [23:0] sample_in
  input  logic                           s_axis_tuser_i,  // [0] channel
  // Output stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [23:0]                    m_axis_tdata_o,  // [23:0] sample_out
  output logic                           m_axis_tuser_o   // [0] channel_out
);
  import tslm_pkg::*;

  localparam int A_W   = 25;
  localparam int B_W   = 18;
  localparam int P_W   = A_W + B_W;
  localparam int ACC_W = 44;
  localparam int M_W   = 38;                    // |x| * drive
  localparam int POS_W = M_W + $clog2(TANH_DEPTH + 1);
  localparam int K_W   = POS_W - 37;
  localparam int O_W   = ACC_W - 16;

  localparam logic signed [O_W-1:0] SAT_MAX = O_W'(8388607);
  localparam logic signed [O_W-1:0] SAT_MIN = -O_W'(8388608);

  // Microprogram steps
  typedef enum logic [3:0] {
    UC_IDLE, UC_DRIVE, UC_POS, UC_TAB_LO, UC_INTERP_LO, UC_INTERP_HI,
    UC_SCALE, UC_LP_IN, UC_LP_FB, UC_MIX_WET, UC_MIX_DRY, UC_EMIT
  } uc_step_e;

  typedef enum logic [2:0] {
    A_MAG, A_TAB, A_ACC, A_SHAPED, A_LPM, A_X
  } a_sel_e;

  typedef enum logic [2:0] {
    B_DRIVE, B_W_LO, B_W_HI, B_SCALE, B_INV_A, B_A, B_WET, B_DRY
  } b_sel_e;

  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_e;
  typedef enum logic [1:0] {TAB_NONE, TAB_LO, TAB_HI} tab_rd_e;
  typedef enum logic [1:0] {JMP_NEXT, JMP_WAIT_IN, JMP_EMIT} jmp_e;

  typedef struct packed {
    a_sel_e   a_sel;
    b_sel_e   b_sel;
    acc_op_e  acc_op;
    logic     bias;
    tab_rd_e  tab;
    logic     latch_pos;
    logic     wr_lp;
    jmp_e     jmp;
    uc_step_e target;
  } uc_word_t;

  // Control store
  function automatic uc_word_t uc_rom(input uc_step_e s);
    uc_word_t w;
    w = '{a_sel: A_MAG, b_sel: B_DRIVE, acc_op: ACC_HOLD, bias: 1'b0, tab: TAB_NONE,
          latch_pos: 1'b0, wr_lp: 1'b0, jmp: JMP_NEXT, target: UC_IDLE};
    case (s)
      UC_IDLE: begin
        w.jmp = JMP_WAIT_IN;
      end
      UC_DRIVE: begin
        w.a_sel = A_MAG;    w.b_sel = B_DRIVE; w.acc_op = ACC_LOAD;
      end
      UC_POS: begin
        w.latch_pos = 1'b1;
      end
      UC_TAB_LO: begin
        w.tab = TAB_LO;
      end
      UC_INTERP_LO: begin
        w.a_sel = A_TAB;    w.b_sel = B_W_LO;  w.acc_op = ACC_LOAD; w.tab = TAB_HI;
      end
      UC_INTERP_HI: begin
        w.a_sel = A_TAB;    w.b_sel = B_W_HI;  w.acc_op = ACC_ADD;
      end
      UC_SCALE: begin
        w.a_sel = A_ACC;    w.b_sel = B_SCALE; w.acc_op = ACC_LOAD; w.bias = 1'b1;
      end
      UC_LP_IN: begin
        w.a_sel = A_SHAPED; w.b_sel = B_INV_A; w.acc_op = ACC_LOAD;
      end
      UC_LP_FB: begin
        w.a_sel = A_LPM;    w.b_sel = B_A;     w.acc_op = ACC_ADD;  w.bias = 1'b1;
      end
      UC_MIX_WET: begin
        w.a_sel = A_ACC;    w.b_sel = B_WET;   w.acc_op = ACC_LOAD; w.wr_lp = 1'b1;
      end
      UC_MIX_DRY: begin
        w.a_sel = A_X;      w.b_sel = B_DRY;   w.acc_op = ACC_ADD;  w.bias = 1'b1;
      end
      UC_EMIT: begin
        w.jmp = JMP_EMIT;   w.target = UC_IDLE;
      end
      default: begin
        w.jmp = JMP_EMIT;   w.target = UC_IDLE;
      end
    endcase
    return w;
  endfunction

  // Registers
  uc_step_e                    pc_q, pc_d;
  logic                        out_valid_q;
  logic [DRIVE_W-1:0]          drive_q;
  logic [POLE_W-1:0]           pole_q;
  logic [WET_W-1:0]            wet_q;
  logic signed [SAMPLE_W-1:0]  lpm_q [CHANNELS];
  logic signed [SAMPLE_W-1:0]  x_q;
  logic [SAMPLE_W-1:0]         mag_q;
  logic                        ch_q;
  logic [SLOT_W-1:0]           slot_q;
  logic signed [ACC_W-1:0]     acc_q, acc_d;
  logic [IDX_W-1:0]            k_q;
  logic [15:0]                 f_q;
  logic                        sat_q;
  logic [TAB_W-1:0]            tab_q;
  logic [23:0]                 out_data_q;
  logic                        out_ch_q;

  uc_word_t                    uc;
  logic                        in_acc;
  logic                        out_free;
  logic                        emit;
  logic signed [A_W-1:0]       a_op;
  logic signed [B_W-1:0]       b_op;
  logic signed [P_W-1:0]       prod;
  logic signed [ACC_W-1:0]     bias_v;
  logic [POS_W-1:0]            pos_full;
  logic [K_W-1:0]              k_full;
  logic [IDX_W-1:0]            tab_addr;
  logic [WET_W-1:0]            wet_eff;
  logic signed [A_W-1:0]       acc_hi;
  logic signed [O_W-1:0]       o_full;
  logic [23:0]                 o_sat;
  logic [SLOT_W-1:0]           slot_in;

  assign uc       = uc_rom(pc_q);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign emit     = (uc.jmp == JMP_EMIT) && out_free;

  assign s_axis_tready_o = (pc_q == UC_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_ch_q;

  // Channels beyond the memories share the last one
  assign slot_in = ({31'b0, s_axis_tuser_i} < CHANNELS) ? SLOT_W'(s_axis_tuser_i)
                                                        : SLOT_W'(CHANNELS - 1);

  // Sequencer next step
  always_comb begin
    case (uc.jmp)
      JMP_WAIT_IN: pc_d = in_acc ? uc_step_e'(pc_q + 4'd1) : pc_q;
      JMP_EMIT:    pc_d = out_free ? uc.target : pc_q;
      default:     pc_d = uc_step_e'(pc_q + 4'd1);
    endcase
  end

  // Table position from |x| * drive
  assign pos_full = POS_W'(acc_q[M_W-1:0]) * POS_W'(TANH_DEPTH);
  assign k_full   = pos_full[POS_W-1:37];

  // Table address: both reads pin to the end entry when saturated
  always_comb begin
    case (uc.tab)
      TAB_LO:  tab_addr = sat_q ? IDX_W'(TANH_DEPTH) : k_q;
      TAB_HI:  tab_addr = sat_q ? IDX_W'(TANH_DEPTH) : k_q + IDX_W'(1);
      default: tab_addr = k_q;
    endcase
  end

  assign wet_eff = (wet_q > WET_W'(Q16_ONE)) ? WET_W'(Q16_ONE) : wet_q;
  assign acc_hi  = acc_q[A_W+15:16];

  // Multiplier operand A
  always_comb begin
    case (uc.a_sel)
      A_MAG:    a_op = signed'({1'b0, mag_q});
      A_TAB:    a_op = signed'({2'b0, tab_q});
      A_ACC:    a_op = acc_hi;
      A_SHAPED: a_op = x_q[SAMPLE_W-1] ? -acc_hi : acc_hi;
      A_LPM:    a_op = A_W'(lpm_q[slot_q]);
      A_X:      a_op = A_W'(x_q);
      default:  a_op = '0;
    endcase
  end

  // Multiplier operand B
  always_comb begin
    case (uc.b_sel)
      B_DRIVE: b_op = signed'({3'b0, drive_q});
      B_W_LO:  b_op = sat_q ? B_W'(Q16_ONE) : signed'(B_W'(Q16_ONE) - {2'b0, f_q});
      B_W_HI:  b_op = sat_q ? '0 : signed'({2'b0, f_q});
      B_SCALE: b_op = B_W'(SCALE_085);
      B_INV_A: b_op = signed'(B_W'(Q16_ONE) - {2'b0, pole_q});
      B_A:     b_op = signed'({2'b0, pole_q});
      B_WET:   b_op = signed'({1'b0, wet_eff});
      B_DRY:   b_op = signed'(B_W'(Q16_ONE) - {1'b0, wet_eff});
      default: b_op = '0;
    endcase
  end

  // Shared multiplier and accumulator
  assign prod   = a_op * b_op;
  assign bias_v = uc.bias ? ACC_W'(ROUND_HALF) : '0;

  always_comb begin
    case (uc.acc_op)
      ACC_LOAD: acc_d = ACC_W'(prod) + bias_v;
      ACC_ADD:  acc_d = acc_q + ACC_W'(prod) + bias_v;
      default:  acc_d = acc_q;
    endcase
  end

  // Output rounding already in the accumulator; clamp to 24 bits
  assign o_full = acc_q[ACC_W-1:16];
  always_comb begin
    if (o_full > SAT_MAX) begin
      o_sat = 24'h7F_FFFF;
    end else if (o_full < SAT_MIN) begin
      o_sat = 24'h80_0000;
    end else begin
      o_sat = o_full[23:0];
    end
  end

  // Control state, configuration and filter memories
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= UC_IDLE;
      out_valid_q <= 1'b0;
      drive_q     <= DRIVE_RST;
      pole_q      <= POLE_RST;
      wet_q       <= WET_RST;
      for (int c = 0; c < CHANNELS; c++) begin
        lpm_q[c] <= '0;
      end
    end else begin
      pc_q <= pc_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DRIVE_GAIN:   drive_q <= cfg_wdata_i[DRIVE_W-1:0];
          CFG_POLE_COEFF:   pole_q  <= cfg_wdata_i[POLE_W-1:0];
          CFG_WET_FRACTION: wet_q   <= cfg_wdata_i[WET_W-1:0];
          default: ;
        endcase
      end
      if (uc.wr_lp) begin
        lpm_q[slot_q] <= acc_q[SAMPLE_W+15:16];
      end
    end
  end

  // Datapath payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q    <= signed'(s_axis_tdata_i);
      mag_q  <= s_axis_tdata_i[23] ? -s_axis_tdata_i : s_axis_tdata_i;
      ch_q   <= s_axis_tuser_i;
      slot_q <= slot_in;
    end
    acc_q <= acc_d;
    if (uc.latch_pos) begin
      sat_q <= (k_full >= K_W'(TANH_DEPTH));
      k_q   <= k_full[IDX_W-1:0];
      f_q   <= pos_full[36:21];
    end
    if (uc.tab != TAB_NONE) begin
      tab_q <= TANH_TAB[tab_addr];
    end
    if (emit) begin
      out_data_q <= o_sat;
      out_ch_q   <= ch_q;
    end
  end

`ifndef SYNTHESIS
  // An accepted sample starts the program at its first product
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (pc_q == UC_DRIVE))
    else $error("sequencer did not start after input transaction");

  // A full, stalled output register holds the program at its last step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == UC_EMIT) && out_valid_q && !m_axis_tready_i |=> (pc_q == UC_EMIT))
    else $error("result emitted over a pending transaction");

  // Emitting fills the output register and returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> m_axis_tvalid_o && (pc_q == UC_IDLE))
    else $error("emit step did not deliver a result");

  // Unsaturated table index leaves room for the upper neighbor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == UC_TAB_LO) |-> (sat_q || (k_q < IDX_W'(TANH_DEPTH))))
    else $error("tanh table index out of range");
`endif

endmodule

/* bench/tape_saturation_lowpass_mix_tb.sv */
// ----------------------------------------------------------------------------
// tape_saturation_lowpass_mix_tb
// Self-checking bench for the tape saturator. A bit-exact predictor of the
// drive, tanh table, 0.85 scale, per-channel lowpass and dry/wet mix runs
// beside the block. Directed register corners come first, then phases of
// random audio under random settings, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tape_saturation_lowpass_mix_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tslm_pkg::*;

  localparam int  CURVE_PTS     = TANH_DEPTH;
  localparam int  IDLE_LIMIT    = 1000;
  localparam int  SETTLE_CYCLES = 16;
  localparam int  PRINT_CAP     = 20;
  localparam int  RAND_PHASES   = 10;
  localparam int  PHASE_ITEMS   = 73;
  localparam longint ONE_Q16    = 65536;
  localparam longint HALF_Q16   = 32768;
  localparam longint GAIN_085   = 55706;
  localparam longint SAMPLE_MAX = 8388607;
  localparam longint SAMPLE_MIN = -8388608;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                chan;
  } audio_out_t;

  // DUT signals
  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [23:0]          s_axis_tdata_i;   // [23:0] sample_in
  logic                 s_axis_tuser_i;   // [0] channel
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [23:0]          m_axis_tdata_o;   // [23:0] sample_out
  logic                 m_axis_tuser_o;   // [0] channel_out

  // Predictor state: register copies, filter memories, tanh curve
  logic [DRIVE_W-1:0] drive_gain_q;
  logic [POLE_W-1:0]  pole_coeff_q;
  logic [WET_W-1:0]   wet_fraction_q;
  longint             lowpass_mem [CHANNELS];
  longint             tanh_curve [CURVE_PTS+1];

  audio_out_t pending_outputs [$];
  longint     walk_level [2];
  bit         idle_on;
  int         samples_sent;
  int         directed_samples;
  int         results_checked;
  int         reg_writes;
  int         mismatches;
  int         quiet_cycles;

  tape_saturation_lowpass_mix DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Q2.30 product, rounded half up
  function automatic longint unsigned q30_product(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  // tanh(4*i/depth) in Q1.22: short series at 1/64 scale, then six doublings
  function automatic void build_tanh_curve();
    longint unsigned v;
    longint unsigned v2;
    longint unsigned v3;
    longint unsigned v5;
    longint unsigned t;
    longint unsigned den;
    for (int i = 0; i <= CURVE_PTS; i++) begin
      v  = ((longint'(i) << 26) + CURVE_PTS / 2) / CURVE_PTS;
      v2 = q30_product(v, v);
      v3 = q30_product(v2, v);
      v5 = q30_product(v3, v2);
      t  = v - (v3 + 1) / 3 + (2 * v5 + 7) / 15;
      for (int r = 0; r < 6; r++) begin
        den = (64'd1 << 30) + q30_product(t, t);
        t   = ((t << 31) + den / 2) / den;
      end
      t = (t + 128) >> 8;
      if (t > SAMPLE_MAX) begin
        t = SAMPLE_MAX;
      end
      tanh_curve[i] = longint'(t);
    end
  endfunction

  // Expected output of one sample; advances the channel's lowpass memory
  function automatic audio_out_t tape_chain_output(logic [23:0] sample, logic chan);
    longint     x;
    longint     mag;
    longint     pos;
    longint     k;
    longint     f;
    longint     y;
    longint     shaped;
    longint     a;
    longint     lp;
    longint     wet;
    longint     mixed;
    audio_out_t res;
    x   = longint'($signed(sample));
    mag = (x < 0) ? -x : x;
    pos = (mag * longint'(drive_gain_q) * CURVE_PTS) >>> 21;
    k   = pos >>> 16;
    f   = pos & 64'hFFFF;
    if (k >= CURVE_PTS) begin
      y = tanh_curve[CURVE_PTS];
    end else begin
      y = (tanh_curve[k] * (ONE_Q16 - f) + tanh_curve[k+1] * f) >>> 16;
    end
    shaped = (y * GAIN_085 + HALF_Q16) >>> 16;
    if (x < 0) begin
      shaped = -shaped;
    end
    a  = longint'(pole_coeff_q);
    lp = ((ONE_Q16 - a) * shaped + a * lowpass_mem[chan] + HALF_Q16) >>> 16;
    lowpass_mem[chan] = lp;
    wet   = (longint'(wet_fraction_q) > ONE_Q16) ? ONE_Q16 : longint'(wet_fraction_q);
    mixed = ((ONE_Q16 - wet) * x + wet * lp + HALF_Q16) >>> 16;
    if (mixed > SAMPLE_MAX) mixed = SAMPLE_MAX;
    if (mixed < SAMPLE_MIN) mixed = SAMPLE_MIN;
    res.sample = mixed[SAMPLE_W-1:0];
    res.chan   = chan;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint exp_val, longint got_val);
    if (mismatches < PRINT_CAP) begin
      $display("MISMATCH %s at %0t: expected %0d, got %0d", what, $realtime, exp_val,
               got_val);
    end
    mismatches++;
  endtask

  // Output checker
  always @(posedge clk_i) begin
    audio_out_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      results_checked++;
      if (pending_outputs.size() == 0) begin
        report_mismatch("unexpected output transaction", 0, 1);
      end else begin
        want = pending_outputs.pop_front();
        if (m_axis_tdata_o !== want.sample) begin
          report_mismatch("sample_out", longint'($signed(want.sample)),
                          longint'($signed(m_axis_tdata_o)));
        end
        if (m_axis_tuser_o !== want.chan) begin
          report_mismatch("channel_out", longint'(want.chan), longint'(m_axis_tuser_o));
        end
      end
    end
  end

  // Watchdog: cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Output back-pressure: random stall before each result
  initial begin
    int unsigned stall;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = idle_on ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        @(negedge clk_i) m_axis_tready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i) m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid_o && m_axis_tready_i));
    end
  end

  // One register write; the predictor copy follows at the same edge
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_DRIVE_GAIN:   drive_gain_q   = value[DRIVE_W-1:0];
      CFG_POLE_COEFF:   pole_coeff_q   = value[POLE_W-1:0];
      CFG_WET_FRACTION: wet_fraction_q = value[WET_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i) cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(int drive, int pole, int wet);
    write_reg(CFG_DRIVE_GAIN, CFG_W'(drive));
    write_reg(CFG_POLE_COEFF, CFG_W'(pole));
    write_reg(CFG_WET_FRACTION, CFG_W'(wet));
  endtask

  // Send one sample with a random lead-in gap; predict on acceptance
  task automatic send_sample(longint value, logic chan);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      @(negedge clk_i) s_axis_tvalid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value[23:0];
    s_axis_tuser_i  <= chan;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_outputs.push_back(tape_chain_output(value[23:0], chan));
    samples_sent++;
  endtask

  // Stop the input stream and drain; the block is idle afterwards
  task automatic drain_outputs();
    @(negedge clk_i) s_axis_tvalid_i <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Random audio: full range, small levels, rails, or a slow walk per channel
  function automatic longint draw_sample(logic chan);
    int unsigned kind;
    int unsigned bits;
    longint      v;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      v = longint'($signed(24'($urandom)));
    end else if (kind < 65) begin
      bits = $urandom_range(1, 23);
      v    = longint'($urandom) & ((64'd1 << bits) - 1);
      if ($urandom_range(0, 1)) v = -v;
    end else if (kind < 80) begin
      v = $urandom_range(0, 1) ? SAMPLE_MAX - $urandom_range(0, 255)
                               : SAMPLE_MIN + $urandom_range(0, 255);
    end else begin
      v = walk_level[chan] + longint'($urandom_range(0, 262144)) - 131072;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      if (v < SAMPLE_MIN) v = SAMPLE_MIN;
      walk_level[chan] = v;
    end
    return v;
  endfunction

  // Register defaults straight out of reset
  task automatic test_reset_defaults();
    send_sample(0, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(1, 1'b1);
    drain_outputs();
  endtask

  // Drive below one, above seven, and the table end at magnitude four
  task automatic test_drive_range();
    set_regs(0, 60000, 65536);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(-4194304, 1'b1);
    drain_outputs();
    set_regs(32767, 60000, 65536);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(-1, 1'b1);
    drain_outputs();
    set_regs(4096, 60000, 65536);
    send_sample(24'h200000, 1'b0);
    send_sample(-SAMPLE_MAX, 1'b1);
    drain_outputs();
    set_regs(16384, 60000, 65536);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    drain_outputs();
  endtask

  // Lowpass with no memory and with almost all memory
  task automatic test_pole_extremes();
    set_regs(11469, 0, 65536);
    send_sample(3000000, 1'b0);
    send_sample(-3000000, 1'b1);
    drain_outputs();
    set_regs(11469, 65535, 65536);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    drain_outputs();
  endtask

  // Dry only, half mix, and wet values above one
  task automatic test_wet_mix();
    set_regs(20000, 30000, 0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    drain_outputs();
    write_reg(CFG_WET_FRACTION, CFG_W'(65537));
    send_sample(5000000, 1'b0);
    drain_outputs();
    write_reg(CFG_WET_FRACTION, CFG_W'(131071));
    send_sample(-5000000, 1'b1);
    drain_outputs();
    write_reg(CFG_WET_FRACTION, CFG_W'(32768));
    send_sample(123456, 1'b0);
    send_sample(-7654321, 1'b1);
    drain_outputs();
  endtask

  // Phases of random audio, each under fresh random or corner settings
  task automatic test_random_traffic();
    int  drive;
    int  pole;
    int  wet;
    bit  chan;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drive = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                          : $urandom_range(4096, 28672);
      case ($urandom_range(0, 3))
        0:       pole = $urandom_range(0, 65535);
        1:       pole = $urandom_range(0, 1) ? 65535 : 0;
        default: pole = $urandom_range(50000, 65535);
      endcase
      case ($urandom_range(0, 4))
        0:       wet = $urandom_range(65536, 131071);
        1:       wet = $urandom_range(0, 1) ? 65536 : 0;
        default: wet = $urandom_range(0, 65536);
      endcase
      set_regs(drive, pole, wet);
      idle_on = (ph % 3 != 2);
      chan    = 1'($urandom_range(0, 1));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // mostly alternating stereo pairs, sometimes runs on one channel
        if ($urandom_range(0, 3) != 0) chan = ~chan;
        send_sample(draw_sample(chan), chan);
      end
      drain_outputs();
    end
  endtask

  // Reset, test sequence, final verdict
  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_DRIVE_GAIN;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    idle_on         = 1'b1;
    samples_sent     = 0;
    results_checked  = 0;
    reg_writes       = 0;
    mismatches       = 0;
    quiet_cycles     = 0;
    walk_level[0]    = 0;
    walk_level[1]    = 0;
    drive_gain_q     = DRIVE_W'(11469);
    pole_coeff_q     = POLE_W'(60000);
    wet_fraction_q   = WET_W'(65536);
    for (int c = 0; c < CHANNELS; c++) lowpass_mem[c] = 0;
    build_tanh_curve();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    test_reset_defaults();
    test_drive_range();
    test_pole_extremes();
    test_wet_mix();
    directed_samples = samples_sent;
    test_random_traffic();

    drain_outputs();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Covered %0d samples (%0d directed) and %0d register writes",
             samples_sent, directed_samples, reg_writes);
    $display("Checked %0d output transactions, %0d mismatches", results_checked,
             mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
